@@ src/rhp_pkg.sv @@
package rhp_pkg;

	localparam int KEY_W = 64;
	localparam int DEST_W = 32;
	localparam int BIN_W = 14;
	localparam int PART_W = 4;
	localparam logic [PART_W-1:0] PART_BITS_RESET = 4'd4;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_COUNT  = 2'd1,
		MODE_PREFIX = 2'd2,
		MODE_PLACE  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t            mode;
		logic [KEY_W-1:0] key;
	} item_t;

	typedef struct packed {
		logic [DEST_W-1:0] dest_index;
		logic [KEY_W-1:0]  placed_key;
		logic [BIN_W-1:0]  bin;
		logic              valid_res;
		logic              overflow;
	} result_t;

endpackage

@@ src/rhp_ram.sv @@
module rhp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/rhp_front.sv @@
module rhp_front #(
	parameter int MAX_PART_BITS = 14,
	parameter int ABW = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  rhp_pkg::item_t            in_item,
	input  logic [ABW-1:0]            active_bits,
	input  logic                      init_busy,
	output logic                      q_valid,
	input  logic                      q_ready,
	output rhp_pkg::item_t            q_item,
	output logic [MAX_PART_BITS-1:0]  q_bin
);

	rhp_pkg::item_t           item_q [2];
	logic [MAX_PART_BITS-1:0] bin_q [2];
	logic                     wr_ptr_q;
	logic                     rd_ptr_q;
	logic [1:0]               count_q;
	logic                     push;
	logic                     pop;
	logic [MAX_PART_BITS-1:0] bin_mask;
	logic [MAX_PART_BITS-1:0] in_bin;

	// bin select: low key bits under the active mask
	assign bin_mask = ~({MAX_PART_BITS{1'b1}} << active_bits);
	assign in_bin   = in_item.key[MAX_PART_BITS-1:0] & bin_mask;

	assign in_ready = (count_q != 2'd2) && !init_busy;
	assign q_valid  = (count_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_item   = item_q[rd_ptr_q];
	assign q_bin    = bin_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q] <= in_item;
			bin_q[wr_ptr_q]  <= in_bin;
		end
	end

endmodule

@@ src/rhp_back.sv @@
module rhp_back #(
	parameter int MAX_PART_BITS = 14,
	parameter int INDEX_BITS = 32,
	parameter int ABW = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	output logic                     q_ready,
	input  rhp_pkg::item_t           q_item,
	input  logic [MAX_PART_BITS-1:0] q_bin,
	input  logic [ABW-1:0]           active_bits,
	output logic                     init_busy,
	output logic                     out_valid,
	input  logic                     out_ready,
	output rhp_pkg::result_t         out_res
);

	localparam int AW = MAX_PART_BITS;
	localparam int DEPTH = 1 << MAX_PART_BITS;

	typedef enum logic [4:0] {
		ST_INIT   = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_RMW    = 5'b00100,
		ST_CLEAR  = 5'b01000,
		ST_PREFIX = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [AW-1:0]            idx_q;
	logic [INDEX_BITS-1:0]    sum_q;
	logic                     ovf_q;
	rhp_pkg::item_t           cur_q;
	logic [AW-1:0]            cur_bin_q;
	logic                     out_valid_q;
	rhp_pkg::result_t         res_q;

	logic                     take;
	logic                     load;
	rhp_pkg::result_t         res_d;
	logic                     we;
	logic [AW-1:0]            waddr;
	logic [INDEX_BITS-1:0]    wdata;
	logic [AW-1:0]            raddr;
	logic [INDEX_BITS-1:0]    rdata;
	logic                     at_max;
	logic [INDEX_BITS-1:0]    inc_val;
	logic [INDEX_BITS:0]      sum_add;
	logic                     sum_sat;
	logic [INDEX_BITS-1:0]    sum_next;
	logic [AW-1:0]            last_idx;
	logic [INDEX_BITS+31:0]   dest_ext;
	logic [AW+13:0]           bin_ext;

	rhp_ram #(
		.WIDTH(INDEX_BITS),
		.DEPTH(DEPTH)
	) u_bins (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign init_busy = (state_q == ST_INIT);
	assign take      = (state_q == ST_IDLE) && q_valid && (!out_valid_q || out_ready);
	assign q_ready   = take;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	assign last_idx = ~({AW{1'b1}} << active_bits);
	assign at_max   = &rdata;
	assign inc_val  = at_max ? rdata : rdata + INDEX_BITS'(1);
	assign sum_add  = {1'b0, sum_q} + {1'b0, rdata};
	assign sum_sat  = sum_add[INDEX_BITS];
	assign sum_next = sum_sat ? {INDEX_BITS{1'b1}} : sum_add[INDEX_BITS-1:0];
	assign dest_ext = {32'b0, rdata};
	assign bin_ext  = {14'b0, cur_bin_q};

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = '0;
		raddr = q_bin;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				we = 1'b1;
			end
			ST_RMW: begin
				we    = 1'b1;
				waddr = cur_bin_q;
				wdata = inc_val;
			end
			ST_PREFIX: begin
				// write offset of this bin while reading the next one
				we    = 1'b1;
				wdata = sum_q;
				raddr = idx_q + AW'(1);
			end
			ST_IDLE: begin
				if (q_item.mode == rhp_pkg::MODE_PREFIX) begin
					raddr = '0;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// result of the item finishing this cycle
	always_comb begin
		load  = 1'b0;
		res_d = '0;
		case (state_q)
			ST_RMW: begin
				load           = 1'b1;
				res_d.bin      = bin_ext[13:0];
				res_d.overflow = at_max;
				if (cur_q.mode == rhp_pkg::MODE_PLACE) begin
					res_d.dest_index = dest_ext[31:0];
					res_d.placed_key = cur_q.key;
					res_d.valid_res  = 1'b1;
				end
			end
			ST_CLEAR: begin
				load = &idx_q;
			end
			ST_PREFIX: begin
				load           = (idx_q == last_idx);
				res_d.overflow = ovf_q || sum_sat;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			idx_q       <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					idx_q <= idx_q + AW'(1);
					if (&idx_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						idx_q <= '0;
						sum_q <= '0;
						ovf_q <= 1'b0;
						case (q_item.mode)
							rhp_pkg::MODE_CLEAR:  state_q <= ST_CLEAR;
							rhp_pkg::MODE_PREFIX: state_q <= ST_PREFIX;
							default:              state_q <= ST_RMW;
						endcase
					end
				end
				ST_RMW: begin
					state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					idx_q <= idx_q + AW'(1);
					if (&idx_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PREFIX: begin
					sum_q <= sum_next;
					ovf_q <= ovf_q || sum_sat;
					idx_q <= idx_q + AW'(1);
					if (idx_q == last_idx) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q     <= q_item;
			cur_bin_q <= q_bin;
		end
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule

@@ src/radix_hash_partitioner.sv @@
// radix partitioner for 64-bit keys, binned by the low part_bits key bits
// input stream: tuser carries the mode (clear, count, prefix, place), tdata the key;
// every accepted beat gives exactly one output beat, in input order
// output stream: tdata holds dest_index, placed_key, bin and overflow, tuser valid_res
// cfg channel writes part_bits; write only while no beat is in flight
// a two-entry queue sits between the input side and the bin engine
// count and place: one read-modify-write of the bin memory, 2 engine cycles,
// about 3 cycles from input beat to output beat
// clear: one memory write per bin, 2^MAX_PART_BITS + 1 cycles
// prefix: one read and one write per active bin, 2^part_bits + 1 cycles
// after reset the bin memory is zeroed in 2^MAX_PART_BITS cycles (16384 by
// default) with s_axis_tready low; part_bits resets to 4
// a stalled output holds its beat in the output register; the queue keeps
// accepting until it is full, then s_axis_tready drops
module radix_hash_partitioner #(
	parameter int MAX_PART_BITS = 14,
	parameter int INDEX_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // key
	input  logic [1:0]   s_axis_tuser,   // mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [111:0] m_axis_tdata,   // dest_index, placed_key, bin, overflow, zero pad
	output logic [0:0]   m_axis_tuser,   // valid_res
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [3:0]   cfg_data        // part_bits
);

	localparam int ABW = $clog2(MAX_PART_BITS + 1);

	logic [rhp_pkg::PART_W-1:0] part_bits_q;
	logic [ABW-1:0]             active_bits;
	rhp_pkg::item_t             in_item;
	logic                       q_valid;
	logic                       q_ready;
	rhp_pkg::item_t             q_item;
	logic [MAX_PART_BITS-1:0]   q_bin;
	logic                       init_busy;
	rhp_pkg::result_t           res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_bits_q <= rhp_pkg::PART_BITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			part_bits_q <= cfg_data;
		end
	end

	// values above the table size act as the largest size
	assign active_bits = ({28'b0, part_bits_q} > MAX_PART_BITS) ? ABW'(MAX_PART_BITS)
		: ABW'(part_bits_q);

	assign in_item.mode = rhp_pkg::mode_t'(s_axis_tuser);
	assign in_item.key  = s_axis_tdata;

	rhp_front #(
		.MAX_PART_BITS(MAX_PART_BITS),
		.ABW(ABW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.active_bits(active_bits),
		.init_busy  (init_busy),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item),
		.q_bin      (q_bin)
	);

	rhp_back #(
		.MAX_PART_BITS(MAX_PART_BITS),
		.INDEX_BITS(INDEX_BITS),
		.ABW(ABW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item),
		.q_bin      (q_bin),
		.active_bits(active_bits),
		.init_busy  (init_busy),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res)
	);

	assign m_axis_tdata = {1'b0, res.overflow, res.bin, res.placed_key, res.dest_index};
	assign m_axis_tuser = res.valid_res;

`ifndef ASSERT_OFF
	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !s_axis_tready)
		else $error("input accepted during memory init");

	a_take_needs_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("engine took an item with the output register blocked");

	a_non_place_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[95:0] == 96'b0))
		else $error("non-place beat carries a destination or key");
`endif

endmodule
